FILE: rtl/assert_macros.svh
// Assertion macros for the top RTL module. Each one expects the including
// module to have a clock named clock and an active-high reset named reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_HOLDS(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_HOLDS(lbl, prop)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/rrcp_pkg.sv
`default_nettype none
package rrcp_pkg;
   localparam int COORD_BITS = 32;
   localparam int FRAC_BITS  = 16;
   localparam int EPS_BITS   = 16;
   localparam int CDIFF_W    = COORD_BITS + 1;
   localparam int DOT_W      = 2 * COORD_BITS + 3;
   localparam int DIFF_W     = 2 * DOT_W + 1;
   localparam int Q_W        = COORD_BITS + 2;
   localparam int DIV_W      = DIFF_W + Q_W + FRAC_BITS + 2;
   localparam int NUM_CELLS  = Q_W;
   localparam int PNT_W      = 2 * COORD_BITS + 2;
   localparam int SPLIT_W    = (DOT_W + 1) / 2;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic      found;
      logic      neg;
      coord_type s1_x;
      coord_type s1_y;
      coord_type s1_z;
      coord_type dir_x;
      coord_type dir_y;
      coord_type dir_z;
   } side_type;

   typedef struct packed {
      logic             valid;
      logic [DIV_W-1:0] rem;
      logic [DIV_W-1:0] dvs;
      logic [Q_W-1:0]   quo;
      side_type         side;
   } div_type;
endpackage
`default_nettype wire

FILE: rtl/rrcp_div_cell.sv
`default_nettype none
module rrcp_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  rrcp_pkg::div_type cell_in,
   output rrcp_pkg::div_type cell_out
);
   rrcp_pkg::div_type out_ff, out_in;
   logic take;
   logic [rrcp_pkg::DIV_W-1:0] diff;

   always_comb begin
      take = cell_in.rem >= cell_in.dvs;
      diff = cell_in.rem - cell_in.dvs;
      out_in = cell_in;
      out_in.rem = take ? diff : cell_in.rem;
      out_in.dvs = cell_in.dvs >> 1;
      out_in.quo = {cell_in.quo[rrcp_pkg::Q_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (en) begin
         out_ff <= out_in;
      end
   end

   assign cell_out = out_ff;
endmodule
`default_nettype wire

FILE: rtl/ray_ray_closest_point_top.sv
`default_nettype none
`include "assert_macros.svh"
// Closest point on ray 1 to ray 2, signed Q16.16 in and out. One ray pair is
// taken every cycle while req_tready is high, and its result reaches rsp
// through ten register stages for the dot products, the split determinant
// and numerator products, time scaling and point rounding, plus a row of 34
// divider cells that each settle one quotient bit of the time. The whole
// pipeline advances whenever the output register is empty or being taken, so
// req_tready drops only while a result waits on rsp. Pairs with a near-zero
// direction or determinant return found 0, time 0 and the start of ray 1.
// The user must write the epsilon through csr_ only while idle; the block does not enforce it.
module ray_ray_closest_point_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // first_start_x/y/z, first_dir_x/y/z, second_start_x/y/z, second_dir_x/y/z
   input  logic [383:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // closest_time, closest_x, closest_y, closest_z
   output logic [127:0] rsp_tdata,
   // found
   output logic [0:0]   rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [15:0]  csr_data
);
   localparam int C  = rrcp_pkg::COORD_BITS;
   localparam int F  = rrcp_pkg::FRAC_BITS;
   localparam int DW = rrcp_pkg::DOT_W;
   localparam int XW = rrcp_pkg::DIFF_W;
   localparam int VW = rrcp_pkg::DIV_W;
   localparam int QW = rrcp_pkg::Q_W;
   localparam int PW = rrcp_pkg::PNT_W;
   localparam int NC = rrcp_pkg::NUM_CELLS;
   localparam int LW = rrcp_pkg::SPLIT_W;
   localparam int HW = DW - LW;

   logic en;
   logic [rrcp_pkg::EPS_BITS-1:0] eps_ff;

   // stage 1
   logic v1_ff;
   logic signed [C-1:0] s1_1_ff [3], a_1_ff [3], b_1_ff [3];
   logic signed [rrcp_pkg::CDIFF_W-1:0] c_1_ff [3];
   // stage 2
   logic v2_ff;
   logic signed [C-1:0] s1_2_ff [3], a_2_ff [3];
   logic signed [DW-1:0] paa_ff [3], pab_ff [3], pac_ff [3], pbb_ff [3], pbc_ff [3];
   // stage 3
   logic v3_ff;
   logic signed [C-1:0] s1_3_ff [3], a_3_ff [3];
   logic signed [DW-1:0] aa_ff, ab_ff, ac_ff, bb_ff, bc_ff;
   // partial products of the determinant and numerator terms
   logic vm_ff, dz_m_ff;
   logic signed [C-1:0] s1_m_ff [3], a_m_ff [3];
   logic signed [DW-1:0] mx [4], my [4];
   logic [2*LW-1:0] pll_ff [4];
   logic signed [LW+HW:0] plh_ff [4], phl_ff [4];
   logic signed [2*HW-1:0] phh_ff [4];
   logic signed [XW-1:0] prod [4];
   // stage 4
   logic v4_ff, dz_4_ff;
   logic signed [C-1:0] s1_4_ff [3], a_4_ff [3];
   logic signed [XW-1:0] m1_ff, m2_ff, n1_ff, n2_ff;
   // stage 5
   logic v5_ff, dz_5_ff;
   logic signed [C-1:0] s1_5_ff [3], a_5_ff [3];
   logic signed [XW-1:0] den_ff, num_ff;
   // divider input and chain
   rrcp_pkg::div_type div_ff, div_in;
   rrcp_pkg::div_type chain [NC+1];
   logic [XW-1:0] dabs, nabs;
   // time stage
   logic vt_ff;
   rrcp_pkg::side_type st_ff;
   logic signed [C-1:0] t_ff, t_in;
   logic [QW-1:0] qv;
   // point product stage
   logic vp_ff, fp_ff;
   logic signed [C-1:0] tp_ff, s1_p_ff [3];
   logic signed [2*C-1:0] pr_ff [3];
   // output
   logic out_v_ff, out_found_ff;
   logic signed [C-1:0] out_t_ff, out_p_ff [3], out_p_in [3];
   logic signed [PW-1:0] psum [3];
   logic [PW-1:0] pmag [3];
   logic [PW-1:0] prnd [3];

   assign en = !out_v_ff || rsp_tready;
   assign req_tready = en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= 16'd1;
      end else if (csr_valid) begin
         eps_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vm_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         vt_ff <= 1'b0;
         vp_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         vm_ff <= v3_ff;
         v4_ff <= vm_ff;
         v5_ff <= v4_ff;
         vt_ff <= chain[NC].valid;
         vp_ff <= vt_ff;
         out_v_ff <= vp_ff;
      end
   end

   always_comb begin
      mx[0] = aa_ff;
      my[0] = bb_ff;
      mx[1] = ab_ff;
      my[1] = ab_ff;
      mx[2] = ac_ff;
      my[2] = bb_ff;
      mx[3] = ab_ff;
      my[3] = bc_ff;
      for (int p = 0; p < 4; p++) begin
         prod[p] = (XW'(phh_ff[p]) <<< (2 * LW))
                 + ((XW'(plh_ff[p]) + XW'(phl_ff[p])) <<< LW)
                 + XW'(pll_ff[p]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s1_1_ff[i] <= req_tdata[i*C +: C];
            a_1_ff[i]  <= req_tdata[(3+i)*C +: C];
            b_1_ff[i]  <= req_tdata[(9+i)*C +: C];
            c_1_ff[i]  <= $signed({req_tdata[(6+i)*C+C-1], req_tdata[(6+i)*C +: C]})
                        - $signed({req_tdata[i*C+C-1], req_tdata[i*C +: C]});
            s1_2_ff[i] <= s1_1_ff[i];
            a_2_ff[i]  <= a_1_ff[i];
            paa_ff[i]  <= DW'(a_1_ff[i] * a_1_ff[i]);
            pab_ff[i]  <= DW'(a_1_ff[i] * b_1_ff[i]);
            pac_ff[i]  <= DW'(a_1_ff[i] * c_1_ff[i]);
            pbb_ff[i]  <= DW'(b_1_ff[i] * b_1_ff[i]);
            pbc_ff[i]  <= DW'(b_1_ff[i] * c_1_ff[i]);
            s1_3_ff[i] <= s1_2_ff[i];
            a_3_ff[i]  <= a_2_ff[i];
            s1_m_ff[i] <= s1_3_ff[i];
            a_m_ff[i]  <= a_3_ff[i];
            s1_4_ff[i] <= s1_m_ff[i];
            a_4_ff[i]  <= a_m_ff[i];
            s1_5_ff[i] <= s1_4_ff[i];
            a_5_ff[i]  <= a_4_ff[i];
         end
         aa_ff <= paa_ff[0] + paa_ff[1] + paa_ff[2];
         ab_ff <= pab_ff[0] + pab_ff[1] + pab_ff[2];
         ac_ff <= pac_ff[0] + pac_ff[1] + pac_ff[2];
         bb_ff <= pbb_ff[0] + pbb_ff[1] + pbb_ff[2];
         bc_ff <= pbc_ff[0] + pbc_ff[1] + pbc_ff[2];
         for (int p = 0; p < 4; p++) begin
            pll_ff[p] <= mx[p][LW-1:0] * my[p][LW-1:0];
            plh_ff[p] <= $signed({1'b0, mx[p][LW-1:0]}) * $signed(my[p][DW-1:LW]);
            phl_ff[p] <= $signed(mx[p][DW-1:LW]) * $signed({1'b0, my[p][LW-1:0]});
            phh_ff[p] <= $signed(mx[p][DW-1:LW]) * $signed(my[p][DW-1:LW]);
         end
         dz_m_ff <= ($unsigned(aa_ff) <= (DW'(eps_ff) << F))
                 || ($unsigned(bb_ff) <= (DW'(eps_ff) << F));
         m1_ff <= prod[0];
         m2_ff <= prod[1];
         n1_ff <= prod[2];
         n2_ff <= prod[3];
         dz_4_ff <= dz_m_ff;
         den_ff <= m1_ff - m2_ff;
         num_ff <= n1_ff - n2_ff;
         dz_5_ff <= dz_4_ff;
      end
   end

   always_comb begin
      dabs = den_ff[XW-1] ? $unsigned(-den_ff) : $unsigned(den_ff);
      nabs = num_ff[XW-1] ? $unsigned(-num_ff) : $unsigned(num_ff);
      div_in = '0;
      div_in.valid = v5_ff;
      div_in.rem = (VW'(nabs) << (F + 1)) + VW'(dabs);
      div_in.dvs = VW'(dabs) << QW;
      div_in.side.found = !dz_5_ff && !(dabs <= (XW'(eps_ff) << (3 * F)));
      div_in.side.neg = num_ff[XW-1] ^ den_ff[XW-1];
      div_in.side.s1_x = s1_5_ff[0];
      div_in.side.s1_y = s1_5_ff[1];
      div_in.side.s1_z = s1_5_ff[2];
      div_in.side.dir_x = a_5_ff[0];
      div_in.side.dir_y = a_5_ff[1];
      div_in.side.dir_z = a_5_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff.valid <= 1'b0;
      end else if (en) begin
         div_ff <= div_in;
      end
   end

   assign chain[0] = div_ff;
   for (genvar g = 0; g < NC; g++) begin : g_cell
      rrcp_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .cell_in (chain[g]),
         .cell_out(chain[g+1])
      );
   end

   always_comb begin
      qv = chain[NC].quo;
      if (!chain[NC].side.found) begin
         t_in = '0;
      end else if (!chain[NC].side.neg) begin
         t_in = (qv >= (QW'(1) << (C - 1))) ? {1'b0, {(C-1){1'b1}}} : $signed(qv[C-1:0]);
      end else begin
         t_in = (qv > (QW'(1) << (C - 1))) ? {1'b1, {(C-1){1'b0}}}
                                            : -$signed(qv[C-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff <= chain[NC].side;
         t_ff <= t_in;
         fp_ff <= st_ff.found;
         tp_ff <= t_ff;
         s1_p_ff[0] <= st_ff.s1_x;
         s1_p_ff[1] <= st_ff.s1_y;
         s1_p_ff[2] <= st_ff.s1_z;
         pr_ff[0] <= st_ff.dir_x * t_ff;
         pr_ff[1] <= st_ff.dir_y * t_ff;
         pr_ff[2] <= st_ff.dir_z * t_ff;
         out_found_ff <= fp_ff;
         out_t_ff <= tp_ff;
         for (int i = 0; i < 3; i++) begin
            out_p_ff[i] <= out_p_in[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         psum[i] = (PW'(s1_p_ff[i]) <<< F) + PW'(pr_ff[i]);
         pmag[i] = psum[i][PW-1] ? $unsigned(-psum[i]) : $unsigned(psum[i]);
         prnd[i] = (pmag[i] + (PW'(1) << (F - 1))) >> F;
         if (!fp_ff) begin
            out_p_in[i] = s1_p_ff[i];
         end else if (!psum[i][PW-1]) begin
            out_p_in[i] = (prnd[i] >= (PW'(1) << (C - 1))) ? {1'b0, {(C-1){1'b1}}}
                                                         : $signed(prnd[i][C-1:0]);
         end else begin
            out_p_in[i] = (prnd[i] > (PW'(1) << (C - 1))) ? {1'b1, {(C-1){1'b0}}}
                                                        : -$signed(prnd[i][C-1:0]);
         end
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata = {out_p_ff[2], out_p_ff[1], out_p_ff[0], out_t_ff};
   assign rsp_tuser = out_found_ff;

   `ASSERT_HOLDS(a_lost_time_zero, !(out_v_ff && !out_found_ff) || out_t_ff == '0)
   `ASSERT_HOLDS(a_ready_follows_out, req_tready == (!rsp_tvalid || rsp_tready))
   `ASSERT_NEXT(a_stall_freezes_tail, vp_ff && out_v_ff && !rsp_tready, out_v_ff && vp_ff && $stable(out_t_ff))
endmodule
`default_nettype wire

FILE: bench/closest_point_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module closest_point_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [383:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [127:0] rsp_tdata,
   input  logic [0:0]   rsp_tuser,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [15:0]  csr_data,
   output int           error_count,
   output int           pending_count
);
   typedef logic signed [255:0] wide_type;

   typedef struct packed {
      logic        found;
      logic [31:0] t;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
   } answer_type;

   logic [15:0] epsilon;
   answer_type  answer_queue[$];

   function automatic wide_type sx(logic [31:0] v);
      return wide_type'($signed(v));
   endfunction

   function automatic wide_type mag(wide_type v);
      return v < 0 ? -v : v;
   endfunction

   function automatic logic [31:0] clamp(wide_type v);
      if (v > 256'sd2147483647) return 32'h7fffffff;
      if (v < -256'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   function automatic answer_type solve_pair(logic [383:0] d, logic [15:0] eps);
      wide_type s1[3], a[3], b[3], c[3];
      wide_type aa, ab, ac, bb, bc, den, num, q, tt, p, rp;
      answer_type r;
      for (int i = 0; i < 3; i++) begin
         s1[i] = sx(d[32*i +: 32]);
         a[i]  = sx(d[32*(3+i) +: 32]);
         c[i]  = sx(d[32*(6+i) +: 32]) - s1[i];
         b[i]  = sx(d[32*(9+i) +: 32]);
      end
      aa = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
      ab = a[0]*b[0] + a[1]*b[1] + a[2]*b[2];
      ac = a[0]*c[0] + a[1]*c[1] + a[2]*c[2];
      bb = b[0]*b[0] + b[1]*b[1] + b[2]*b[2];
      bc = b[0]*c[0] + b[1]*c[1] + b[2]*c[2];
      den = aa*bb - ab*ab;
      r.found = 1'b0;
      r.t = '0;
      r.x = d[31:0];
      r.y = d[63:32];
      r.z = d[95:64];
      if (mag(aa) <= (wide_type'(eps) <<< 16) || mag(bb) <= (wide_type'(eps) <<< 16)
          || mag(den) <= (wide_type'(eps) <<< 48))
         return r;
      num = ac*bb - ab*bc;
      q = ((mag(num) <<< 17) + mag(den)) / (mag(den) <<< 1);
      if ((num < 0) != (den < 0)) q = -q;
      r.found = 1'b1;
      r.t = clamp(q);
      tt = sx(r.t);
      for (int i = 0; i < 3; i++) begin
         p = (s1[i] <<< 16) + a[i]*tt;
         rp = (mag(p) + 256'sd32768) >>> 16;
         if (p < 0) rp = -rp;
         case (i)
            0: r.x = clamp(rp);
            1: r.y = clamp(rp);
            default: r.z = clamp(rp);
         endcase
      end
      return r;
   endfunction

   assign pending_count = answer_queue.size();

   always @(posedge clock) begin
      answer_type exp_a, got;
      if (reset) begin
         epsilon <= 16'd1;
         error_count <= 0;
         answer_queue.delete();
      end else begin
         if (csr_valid && csr_ready) epsilon <= csr_data;
         if (req_tvalid && req_tready) answer_queue.push_back(solve_pair(req_tdata, epsilon));
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser[0], rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64],
                   rsp_tdata[127:96]};
            if (answer_queue.size() == 0) begin
               $display("%0t: unexpected beat %h", $time, got);
               error_count <= error_count + 1;
            end else begin
               exp_a = answer_queue.pop_front();
               if (exp_a !== got) begin
                  $display("%0t: mismatch expected %h actual %h", $time, exp_a, got);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end
endmodule
`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [383:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [15:0]  csr_data = '0;
   int           error_count;
   int           pending_count;
   int           cycle_count = 0;
   int           rsp_wait = 0;
   logic         hold_off = 1'b0;

   localparam int CYCLE_LIMIT = 400000;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ray_ray_closest_point_top DUT (.*);

   closest_point_checker checker_i (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("ray_ray_closest_point_top regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      int draw;
      if (reset || hold_off) begin
         rsp_tready <= 1'b0;
      end else if (rsp_tready && rsp_tvalid) begin
         draw = $urandom_range(0, 5);
         rsp_tready <= (draw == 0);
         rsp_wait <= draw;
      end else if (rsp_wait != 0) begin
         rsp_wait <= rsp_wait - 1;
         rsp_tready <= (rsp_wait == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [31:0] pick_coord(int shape);
      case (shape)
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
         2: return 32'($signed($urandom_range(0, 2000)) - 1000);
         default: return {$urandom} >>> $urandom_range(0, 31);
      endcase
   endfunction

   function automatic logic [383:0] random_pair();
      logic [383:0] d;
      int shape;
      shape = $urandom_range(0, 3);
      for (int i = 0; i < 12; i++) d[32*i +: 32] = pick_coord(shape);
      if ($urandom_range(0, 9) == 0)
         for (int i = 0; i < 3; i++) d[32*(9+i) +: 32] = d[32*(3+i) +: 32];
      if ($urandom_range(0, 19) == 0) d[127:96] = $urandom_range(0, 3) - 1;
      return d;
   endfunction

   task automatic send_pair(logic [383:0] d, bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 5) : 0;
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_epsilon(logic [15:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [383:0] make_pair(logic [31:0] s1, logic [31:0] a,
                                              logic [31:0] s2, logic [31:0] b);
      return {b, b, b, s2, s2, s2, a, a, a, s1, s1, s1};
   endfunction

   initial begin
      logic [15:0] eps_list[5];
      eps_list = '{16'd1, 16'd0, 16'hffff, 16'd300, 16'd7};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_pair({32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000,
                 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000}, 1'b0);
      send_pair(make_pair(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000), 1'b0);
      send_pair({32'h7fffffff, 32'h80000000, 32'h7fffffff, {3{32'h80000000}},
                 32'h80000000, 32'h7fffffff, 32'h0, {3{32'h7fffffff}}}, 1'b0);
      send_pair(make_pair(32'h0, 32'h0, 32'h1234, 32'h0001_0000), 1'b0);
      send_pair(make_pair(32'h5, 32'h0001_0000, 32'h0, 32'h0), 1'b0);
      send_pair({32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0,
                 32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0}, 1'b0);
      send_pair({32'h0, 32'h0, 32'h2, 32'h0, 32'h1, 32'h0,
                 32'h0, 32'h0, 32'h7fffffff, 32'h0, 32'h80000000, 32'h0}, 1'b0);
      send_pair({32'h0, 32'h00ff_0000, 32'h0, {3{32'h10}}, 32'h0, 32'h1, 32'h0,
                 32'h7fff_0000, 32'h0, 32'h0}, 1'b0);
      for (int k = 0; k < 8; k++) send_pair(random_pair(), 1'b0);
      drain();
      for (int ph = 0; ph < 5; ph++) begin
         write_epsilon(ph == 4 ? 16'($urandom) : eps_list[ph]);
         send_pair(make_pair(32'h100, 32'h1, 32'h0, 32'h1), 1'b0);
         for (int k = 0; k < 300; k++) begin
            if (ph == 1 && k == 100) begin
               hold_off <= 1'b1;
               fork
                  begin
                     repeat (150) @(posedge clock);
                     hold_off <= 1'b0;
                  end
               join_none
            end
            if (ph == 2 && k == 150) drain();
            send_pair(random_pair(), ph != 3);
         end
         drain();
      end
      if (error_count == 0) begin
         $display("ray_ray_closest_point_top regression: pass");
      end else begin
         $display("ray_ray_closest_point_top regression: fail");
      end
      $finish;
   end
endmodule
`default_nettype wire
